/* hdl/rtd_pkg.sv */
package rtd_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int TID_BITS    = 96;
    localparam int AddrW       = $clog2(TABLE_DEPTH);
    localparam int FillW       = $clog2(TABLE_DEPTH + 1);
    localparam int SlotW       = 6;
    localparam int CountW      = 16;

    // Stored TID keeps only its low TID_BITS bits
    localparam logic [95:0] TidMask = 96'((97'(1) << TID_BITS) - 97'(1));

    // Commands
    localparam logic CmdReport = 1'b0;
    localparam logic CmdLookup = 1'b1;

    // Result status codes
    localparam logic [2:0] StUpdated  = 3'd0;
    localparam logic [2:0] StInserted = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StHit      = 3'd3;
    localparam logic [2:0] StMiss     = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [31:0] epc_high;
        logic [63:0] epc_low;
        logic [31:0] tid_high;
        logic [63:0] tid_low;
        logic [7:0]  antenna;
        logic [15:0] rssi;
        logic [15:0] phase;
        logic [19:0] freq;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [SlotW-1:0]  slot_index;
        logic [31:0]       stored_tid_high;
        logic [63:0]       stored_tid_low;
        logic [7:0]        stored_antenna;
        logic [15:0]       stored_rssi;
        logic [15:0]       stored_phase;
        logic [19:0]       stored_freq;
        logic [CountW-1:0] read_count;
        logic [CountW-1:0] total_reads;
    } t_out_word;

    // Per-entry read data held in the data memory
    typedef struct packed {
        logic [95:0]       tid;
        logic [7:0]        antenna;
        logic [15:0]       rssi;
        logic [15:0]       phase;
        logic [19:0]       freq;
        logic [CountW-1:0] count;
    } t_entry;

    localparam int EntryW = $bits(t_entry);
    localparam int KeyW   = 96;

endpackage

/* hdl/rtd_if.sv */
interface rtd_in_if import rtd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtd_out_if import rtd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/rtd_ram.sv */
module rtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

/* hdl/rfid_tag_dedup_table.sv */
// On an empty table the search is skipped; otherwise the scan ends at the first
// matching slot, and a miss scans all filled slots.
// One word at a time: a new word is accepted only once the result of the last one
// is in the output register; the key memory is scanned one slot per cycle.
// Reset: fill level, read total, control state and output valid clear; memory
// contents are not cleared, slots at or above the fill level are never searched.
module rfid_tag_dedup_table import rtd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtd_in_if.sink     i_in,
    rtd_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    t_in_word          r_item;
    logic [FillW-1:0]  r_fill;
    logic [CountW-1:0] r_total;
    logic [FillW-1:0]  r_rd_addr;
    logic              r_pend;
    logic [AddrW-1:0]  r_pend_addr;
    logic              r_hit;
    logic [AddrW-1:0]  r_slot;
    t_entry            r_old;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [KeyW-1:0]   key_rd;
    t_entry            data_rd;
    logic              key_we;
    logic              data_we;
    logic [AddrW-1:0]  wr_addr;
    t_entry            wr_entry;
    t_out_word         n_out;
    logic              key_match;
    logic              last_slot;
    logic              out_free;
    logic              is_full;
    logic [95:0]       item_tid;

    // Key and data memories, read together at the scan address
    rtd_ram #(.WIDTH(KeyW), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_item.epc_high, r_item.epc_low}),
        .i_rd_addr (r_rd_addr[AddrW-1:0]),
        .o_rd_data (key_rd)
    );

    rtd_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_data_ram (
        .i_clk     (i_clk),
        .i_we      (data_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_rd_addr[AddrW-1:0]),
        .o_rd_data (data_rd)
    );

    assign key_match = (key_rd == {r_item.epc_high, r_item.epc_low});
    assign last_slot = ((FillW'(r_pend_addr) + FillW'(1)) == r_fill);
    assign out_free  = !r_out_valid || o_out.ready;
    assign is_full   = (r_fill == FillW'(TABLE_DEPTH));
    assign item_tid  = {r_item.tid_high, r_item.tid_low} & TidMask;

    // Build the result and the write-back for the finished search
    always_comb begin
        wr_entry.tid     = item_tid;
        wr_entry.antenna = r_item.antenna;
        wr_entry.rssi    = r_item.rssi;
        wr_entry.phase   = r_item.phase;
        wr_entry.freq    = r_item.freq;
        wr_entry.count   = r_hit ? (r_old.count + CountW'(1)) : CountW'(1);
        wr_addr          = r_hit ? r_slot : r_fill[AddrW-1:0];

        n_out            = '0;
        n_out.total_reads = r_total;
        key_we           = 1'b0;
        data_we          = 1'b0;

        case (r_item.cmd)
            CmdLookup: begin
                if (r_hit) begin
                    n_out.status          = StHit;
                    n_out.slot_index      = SlotW'(r_slot);
                    n_out.stored_tid_high = r_old.tid[95:64];
                    n_out.stored_tid_low  = r_old.tid[63:0];
                    n_out.stored_antenna  = r_old.antenna;
                    n_out.stored_rssi     = r_old.rssi;
                    n_out.stored_phase    = r_old.phase;
                    n_out.stored_freq     = r_old.freq;
                    n_out.read_count      = r_old.count;
                end else begin
                    n_out.status = StMiss;
                end
            end
            default: begin
                if (r_hit || !is_full) begin
                    n_out.status          = r_hit ? StUpdated : StInserted;
                    n_out.slot_index      = SlotW'(wr_addr);
                    n_out.stored_tid_high = item_tid[95:64];
                    n_out.stored_tid_low  = item_tid[63:0];
                    n_out.stored_antenna  = r_item.antenna;
                    n_out.stored_rssi     = r_item.rssi;
                    n_out.stored_phase    = r_item.phase;
                    n_out.stored_freq     = r_item.freq;
                    n_out.read_count      = wr_entry.count;
                    n_out.total_reads     = r_total + CountW'(1);
                    data_we               = (r_state == S_DONE) && out_free;
                    key_we                = data_we && !r_hit;
                end else begin
                    n_out.status = StFull;
                end
            end
        endcase
    end

    // Sequencer: accept, scan filled slots, write back and hand off the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result word once taken, raise it when a search finishes
            r_out_valid <= (r_out_valid && !o_out.ready) ||
                           ((r_state == S_DONE) && out_free);
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item    <= i_in.payload;
                        r_rd_addr <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_state   <= (r_fill == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // advance the read address, compare the word that came back
                    r_rd_addr   <= r_rd_addr + FillW'(1);
                    r_pend      <= (r_rd_addr < r_fill);
                    r_pend_addr <= r_rd_addr[AddrW-1:0];
                    if (r_pend) begin
                        if (key_match) begin
                            r_hit   <= 1'b1;
                            r_slot  <= r_pend_addr;
                            r_old   <= data_rd;
                            r_pend  <= 1'b0;
                            r_state <= S_DONE;
                        end else if (last_slot) begin
                            r_hit   <= 1'b0;
                            r_pend  <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out       <= n_out;
                        r_total     <= n_out.total_reads;
                        if (key_we) begin
                            r_fill <= r_fill + FillW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

/* bench/tb_rfid_tag_dedup_table.sv */
module tb_rfid_tag_dedup_table import rtd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KeyPoolSize = 80;
    localparam int LongHold    = 400;

    logic clk;
    logic rst_n;

    rtd_in_if  in_if ();
    rtd_out_if out_if ();

    rfid_tag_dedup_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Table mirror: one entry per slot, filled in slot order
    logic        tag_valid [TABLE_DEPTH];
    logic [95:0] tag_epc   [TABLE_DEPTH];
    logic [95:0] tag_tid   [TABLE_DEPTH];
    logic [7:0]  tag_ant   [TABLE_DEPTH];
    logic [15:0] tag_rssi  [TABLE_DEPTH];
    logic [15:0] tag_phase [TABLE_DEPTH];
    logic [19:0] tag_freq  [TABLE_DEPTH];
    logic [15:0] tag_cnt   [TABLE_DEPTH];
    int          tags_filled;
    logic [15:0] reads_seen;

    t_out_word   predicted_replies [$];
    logic [95:0] key_pool [KeyPoolSize];
    int          mismatch_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_request;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial begin
        #200ms;
        $display("rfid_tag_dedup_table: mismatch");
        $finish;
    end

    // Build a result from the contents of one slot
    function automatic t_out_word entry_word(input logic [2:0] status, input int slot);
        t_out_word r;
        r.status          = status;
        r.slot_index      = SlotW'(slot);
        r.stored_tid_high = tag_tid[slot][95:64];
        r.stored_tid_low  = tag_tid[slot][63:0];
        r.stored_antenna  = tag_ant[slot];
        r.stored_rssi     = tag_rssi[slot];
        r.stored_phase    = tag_phase[slot];
        r.stored_freq     = tag_freq[slot];
        r.read_count      = tag_cnt[slot];
        r.total_reads     = reads_seen;
        return r;
    endfunction

    // Apply one word to the mirror and return the result it should produce
    function automatic t_out_word apply_tag_read(input t_in_word w);
        t_out_word   r;
        logic [95:0] key;
        logic        hit;
        int          slot;
        r    = '0;
        key  = {w.epc_high, w.epc_low};
        hit  = 1'b0;
        slot = 0;
        // lowest valid slot holding the same EPC wins
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!hit && tag_valid[i] && tag_epc[i] == key) begin
                hit  = 1'b1;
                slot = i;
            end
        end
        if (w.cmd == CmdLookup) begin
            if (hit) begin
                return entry_word(StHit, slot);
            end
            r.status      = StMiss;
            r.total_reads = reads_seen;
            return r;
        end
        // drop a new tag when every slot is taken
        if (!hit && tags_filled == TABLE_DEPTH) begin
            r.status      = StFull;
            r.total_reads = reads_seen;
            return r;
        end
        if (!hit) begin
            slot            = tags_filled;
            tag_valid[slot] = 1'b1;
            tag_epc[slot]   = key;
            tag_cnt[slot]   = '0;
            tags_filled++;
        end
        tag_tid[slot]   = {w.tid_high, w.tid_low} & TidMask;
        tag_ant[slot]   = w.antenna;
        tag_rssi[slot]  = w.rssi;
        tag_phase[slot] = w.phase;
        tag_freq[slot]  = w.freq;
        tag_cnt[slot]   = tag_cnt[slot] + 16'd1;
        reads_seen      = reads_seen + 16'd1;
        return entry_word(hit ? StUpdated : StInserted, slot);
    endfunction

    // Compare one result word with the oldest prediction
    task automatic check_reply(input t_out_word act);
        t_out_word exp;
        if (predicted_replies.size() == 0) begin
            $error("unexpected result word: status %0d slot %0d", act.status, act.slot_index);
            mismatch_count++;
            return;
        end
        exp = predicted_replies.pop_front();
        if (act.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, act.status);
            mismatch_count++;
        end
        if (act.slot_index !== exp.slot_index) begin
            $error("slot_index: expected %0d, got %0d", exp.slot_index, act.slot_index);
            mismatch_count++;
        end
        if (act.stored_tid_high !== exp.stored_tid_high) begin
            $error("stored_tid_high: expected %h, got %h",
                   exp.stored_tid_high, act.stored_tid_high);
            mismatch_count++;
        end
        if (act.stored_tid_low !== exp.stored_tid_low) begin
            $error("stored_tid_low: expected %h, got %h",
                   exp.stored_tid_low, act.stored_tid_low);
            mismatch_count++;
        end
        if (act.stored_antenna !== exp.stored_antenna) begin
            $error("stored_antenna: expected %0d, got %0d",
                   exp.stored_antenna, act.stored_antenna);
            mismatch_count++;
        end
        if (act.stored_rssi !== exp.stored_rssi) begin
            $error("stored_rssi: expected %0d, got %0d", exp.stored_rssi, act.stored_rssi);
            mismatch_count++;
        end
        if (act.stored_phase !== exp.stored_phase) begin
            $error("stored_phase: expected %0d, got %0d", exp.stored_phase, act.stored_phase);
            mismatch_count++;
        end
        if (act.stored_freq !== exp.stored_freq) begin
            $error("stored_freq: expected %0d, got %0d", exp.stored_freq, act.stored_freq);
            mismatch_count++;
        end
        if (act.read_count !== exp.read_count) begin
            $error("read_count: expected %0d, got %0d", exp.read_count, act.read_count);
            mismatch_count++;
        end
        if (act.total_reads !== exp.total_reads) begin
            $error("total_reads: expected %0d, got %0d", exp.total_reads, act.total_reads);
            mismatch_count++;
        end
    endtask

    // Result side: check accepted words, then stall at random or hold off on request
    initial begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                check_reply(out_if.payload);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Random read data for a given command and EPC
    function automatic t_in_word make_word(input logic cmd, input logic [95:0] key);
        t_in_word w;
        w.cmd                   = cmd;
        {w.epc_high, w.epc_low} = key;
        {w.tid_high, w.tid_low} = {$urandom, $urandom, $urandom};
        w.antenna               = 8'($urandom);
        w.rssi                  = 16'($urandom);
        w.phase                 = 16'($urandom);
        w.freq                  = 20'($urandom);
        return w;
    endfunction

    // Offer one word after a random gap, hold it until accepted, then predict
    task automatic send_word(input t_in_word w);
        t_out_word pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        @(posedge clk);
        while (in_if.ready !== 1'b1) begin
            @(posedge clk);
        end
        pred              = apply_tag_read(w);
        predicted_replies = {predicted_replies, pred};
    endtask

    // Drop valid and wait for every predicted result
    task automatic drain();
        in_if.valid <= 1'b0;
        while (predicted_replies.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Empty-table lookup, field extremes, update, near-miss keys
    task automatic test_directed();
        t_in_word w;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(make_word(CmdLookup, '0));
        w = make_word(CmdReport, '0);
        {w.tid_high, w.tid_low, w.antenna, w.rssi, w.phase, w.freq} = '0;
        send_word(w);
        w = make_word(CmdReport, '1);
        {w.tid_high, w.tid_low, w.antenna, w.rssi, w.phase, w.freq} = '1;
        send_word(w);
        w = make_word(CmdReport, '0);
        {w.tid_high, w.tid_low, w.antenna, w.rssi, w.phase, w.freq} = '1;
        send_word(w);
        send_word(make_word(CmdLookup, '1));
        // keys one bit away from a stored EPC must not match
        send_word(make_word(CmdLookup, {1'b0, {95{1'b1}}}));
        send_word(make_word(CmdReport, {{95{1'b1}}, 1'b0}));
        send_word(make_word(CmdLookup, {{95{1'b1}}, 1'b0}));
        w = make_word(CmdReport, '1);
        {w.tid_high, w.tid_low, w.antenna, w.rssi, w.phase, w.freq} = '0;
        send_word(w);
        send_word(make_word(CmdLookup, '0));
        send_word(make_word(CmdLookup, {$urandom, $urandom, $urandom}));
        drain();
    endtask

    // Hit slot 0 back to back so its count and the total keep climbing
    task automatic test_repeat_hits();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (20) begin
            send_word(make_word(CmdReport, tag_epc[0]));
        end
        send_word(make_word(CmdLookup, tag_epc[0]));
        drain();
    endtask

    // Mostly pooled keys so that tags repeat; some fresh keys as noise
    task automatic test_random(input int n, input int src_pct, input int snk_pct);
        logic [95:0] key;
        logic        cmd;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        repeat (n) begin
            if ($urandom_range(0, 99) < 15) begin
                key = {$urandom, $urandom, $urandom};
            end else begin
                key = key_pool[$urandom_range(0, KeyPoolSize - 1)];
            end
            cmd = ($urandom_range(0, 99) < 40) ? CmdLookup : CmdReport;
            send_word(make_word(cmd, key));
        end
        drain();
    endtask

    // Hold the result side off while words keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = LongHold;
        repeat (30) begin
            send_word(make_word($urandom_range(0, 1) ? CmdLookup : CmdReport,
                                key_pool[$urandom_range(0, KeyPoolSize - 1)]));
        end
        drain();
    endtask

    // Fill every slot, then report a new tag and revisit the last slot
    task automatic test_full_table();
        logic [95:0] fresh;
        src_idle_pct   = 10;
        sink_stall_pct = 10;
        while (tags_filled < TABLE_DEPTH) begin
            send_word(make_word(CmdReport, {$urandom, $urandom, $urandom}));
        end
        fresh = {$urandom, $urandom, $urandom};
        send_word(make_word(CmdReport, fresh));
        send_word(make_word(CmdLookup, fresh));
        send_word(make_word(CmdReport, tag_epc[TABLE_DEPTH - 1]));
        send_word(make_word(CmdLookup, tag_epc[TABLE_DEPTH - 1]));
        drain();
    endtask

    // Sequence the tests
    initial begin
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 0;
        tags_filled    = 0;
        reads_seen     = '0;
        foreach (tag_valid[i]) begin
            tag_valid[i] = 1'b0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KeyPoolSize; i++) begin
            key_pool[i] = {$urandom, $urandom, $urandom};
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_repeat_hits();
        test_random(180, 0, 0);
        test_random(180, 56, 0);
        test_random(180, 0, 56);
        test_random(180, 10, 10);
        test_backpressure();
        test_full_table();

        // let any stray word surface before deciding
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("rfid_tag_dedup_table: match");
        end else begin
            $display("rfid_tag_dedup_table: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/rtd_pkg.sv
hdl/rtd_if.sv
hdl/rtd_ram.sv
hdl/rfid_tag_dedup_table.sv
bench/tb_rfid_tag_dedup_table.sv
